[sv/bounded_pointer_axis_accumulator_assert.svh]
// Assertion macros for the bounded pointer axis accumulator
`ifndef BOUNDED_POINTER_AXIS_ACCUMULATOR_ASSERT_SVH
`define BOUNDED_POINTER_AXIS_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define BPAA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpaa same-cycle check failed");
`define BPAA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpaa next-cycle check failed");
`else
`define BPAA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BPAA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/bpaa_pkg.sv]
// Shared types and constants for the bounded pointer axis accumulator
`default_nettype none

package bpaa_pkg;

    localparam int AXIS_COUNT_DEF = 3;
    localparam int COORD_BITS_DEF = 16;
    localparam int REG_COUNT      = 3;
    localparam int REG_IDX_W      = 2;
    localparam int AXIS_W         = 2;

    typedef enum logic [0:0] {
        OP_MOVE   = 1'b0,
        OP_PRESET = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LIMIT,
        ST_PRESET,
        ST_CLAMP,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic ld_setup;
        logic mul_limit;
        logic mul_preset;
        logic clamp_en;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_fire;
        logic axis_ok;
        logic op_preset;
        logic div_done;
        logic out_free;
    } t_ctrl_stat;

endpackage

`default_nettype wire

[sv/bpaa_if.sv]
// Item and result stream interfaces
`default_nettype none

interface bpaa_item_if import bpaa_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [0:0]                   operation;
    logic [AXIS_W-1:0]            axis;
    logic signed [COORD_BITS-1:0] amount;

    modport source (output valid, output operation, output axis, output amount, input ready);
    modport sink   (input valid, input operation, input axis, input amount, output ready);
endinterface

interface bpaa_result_if import bpaa_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

`default_nettype wire

[sv/bpaa_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module bpaa_div import bpaa_pkg::*; #(
    parameter int ACC_W = 2 * COORD_BITS_DEF - 1,
    parameter int DIV_W = COORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACC_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [ACC_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_shift;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [DIV_W-1:0] rem_next;

    always_comb begin
        trial    = {r_rem, r_shift[ACC_W-1]};
        diff     = trial - {1'b0, r_div};
        fits     = (trial >= {1'b0, r_div});
        rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ACC_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[ACC_W-2:0], fits};
            r_rem   <= rem_next;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_busy && (r_cnt == CNT_W'(1));
    assign o_quotient = r_shift;

endmodule

`default_nettype wire

[sv/bpaa_ctrl.sv]
// Sequencer that steps one item through setup, multiply, clamp and divide
`default_nettype none

module bpaa_ctrl import bpaa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd,
    output t_state     o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_stat.in_fire) begin
                    n_state = i_stat.axis_ok ? ST_SETUP : ST_DONE;
                end
            end
            ST_SETUP:  n_state = ST_LIMIT;
            ST_LIMIT:  n_state = i_stat.op_preset ? ST_PRESET : ST_CLAMP;
            ST_PRESET: n_state = ST_CLAMP;
            ST_CLAMP:  n_state = ST_DIVIDE;
            ST_DIVIDE: begin
                if (i_stat.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:   o_cmd.in_ready   = 1'b1;
            ST_SETUP:  o_cmd.ld_setup   = 1'b1;
            ST_LIMIT:  o_cmd.mul_limit  = 1'b1;
            ST_PRESET: o_cmd.mul_preset = 1'b1;
            ST_CLAMP:  o_cmd.clamp_en   = 1'b1;
            ST_DIVIDE: o_cmd = '0;
            ST_DONE:   o_cmd.out_load   = i_stat.out_free;
            default:   o_cmd = '0;
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

[sv/bounded_pointer_axis_accumulator.sv]
// Top level: per-axis scaled accumulators with clamp and bit-serial divide
//
//   channel    dir  handshake         payload
//   i_item     in   valid/ready       operation, axis, amount
//   o_result   out  valid/ready       position
//   i_cfg_*    in   write enable      index, data (min, max, scale)
//
// A move passes setup, the range-limit multiply, clamp and the bit-serial
// divide before the next acceptance, and a preset adds the preset multiply;
// an axis out of range goes straight to the done state.
// Reset sets every axis to minimum 0, maximum -1, scale 0 and clears the
// accumulators at once. i_item is ready only between items; a finished beat
// waits in the output register while the next item is taken.
`default_nettype none
`include "bounded_pointer_axis_accumulator_assert.svh"

module bounded_pointer_axis_accumulator import bpaa_pkg::*; #(
    parameter int AXIS_COUNT = AXIS_COUNT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    bpaa_item_if.sink               i_item,
    bpaa_result_if.source           o_result,
    input  logic                    i_cfg_we,
    input  logic [REG_IDX_W-1:0]    i_cfg_index,
    input  logic [3*COORD_BITS-1:0] i_cfg_data
);

    localparam int C      = COORD_BITS;
    localparam int SET_W  = 3 * C;
    localparam int ACC_W  = 2 * C - 1;
    localparam int SPAN_W = C + 2;
    localparam int V_W    = 2 * C + 3;
    localparam int AX_IW  = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam logic [SET_W-1:0] SETUP_RST = {{C{1'b0}}, {C{1'b1}}, {C{1'b0}}};

    logic [SET_W-1:0]        r_setup [AXIS_COUNT];
    logic [ACC_W-1:0]        r_acc   [AXIS_COUNT];
    logic                    r_op_preset;
    logic                    r_bad;
    logic [AX_IW-1:0]        r_idx;
    logic signed [C-1:0]     r_amount;
    logic signed [C-1:0]     r_min;
    logic [C-1:0]            r_d;
    logic signed [SPAN_W-1:0] r_span;
    logic signed [SPAN_W-1:0] r_amt_min;
    logic signed [V_W-1:0]   r_lim;
    logic signed [V_W-1:0]   r_cand;
    logic                    r_out_valid;
    logic signed [C-1:0]     r_position;

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;
    t_state     state;

    logic                    in_fire;
    logic                    axis_ok;
    logic                    cfg_ok;
    logic [SET_W-1:0]        setup_sel;
    logic signed [C-1:0]     f_min;
    logic signed [C-1:0]     f_max;
    logic [C-1:0]            scale_u;
    logic [C-1:0]            scale_abs;
    logic [C-1:0]            d_sel;
    logic signed [SPAN_W-1:0] span;
    logic signed [SPAN_W-1:0] amt_min;
    logic signed [V_W-1:0]   acc_s;
    logic signed [V_W-1:0]   amt_v;
    logic signed [V_W-1:0]   move_cand;
    logic signed [SPAN_W-1:0] mul_a;
    logic signed [C:0]       mul_b;
    logic signed [V_W-1:0]   mul_p;
    logic                    span_pos;
    logic signed [V_W-1:0]   clamp_wide;
    logic [ACC_W-1:0]        clamp_v;
    logic                    div_busy;
    logic                    div_done;
    logic [ACC_W-1:0]        quotient;
    logic signed [C-1:0]     n_position;

    assign axis_ok = (32'(i_item.axis) < 32'(AXIS_COUNT));
    assign in_fire = i_item.valid && cmd.in_ready;
    assign cfg_ok  = (32'(i_cfg_index) < 32'(REG_COUNT))
                  && (32'(i_cfg_index) < 32'(AXIS_COUNT));

    assign stat.in_fire   = in_fire;
    assign stat.axis_ok   = axis_ok;
    assign stat.op_preset = r_op_preset;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !r_out_valid || o_result.ready;

    bpaa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_state (state)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_setup[i] <= SETUP_RST;
            end
        end else if (i_cfg_we && cfg_ok) begin
            r_setup[AX_IW'(i_cfg_index)] <= i_cfg_data;
        end
    end

    // hold the accepted beat
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op_preset <= (t_op'(i_item.operation) == OP_PRESET);
            r_bad       <= !axis_ok;
            r_idx       <= AX_IW'(i_item.axis);
            r_amount    <= i_item.amount;
        end
    end

    always_comb begin
        setup_sel = r_setup[r_idx];
        f_min     = setup_sel[C-1:0];
        f_max     = setup_sel[2*C-1:C];
        scale_u   = setup_sel[3*C-1:2*C];
        scale_abs = scale_u[C-1] ? (~scale_u + 1'b1) : scale_u;
        d_sel     = (scale_abs == '0) ? C'(1) : scale_abs;
        span      = SPAN_W'(f_max) - SPAN_W'(f_min) + SPAN_W'(1);
        amt_min   = SPAN_W'(r_amount) - SPAN_W'(f_min);
        acc_s     = signed'(V_W'(r_acc[r_idx]));
        amt_v     = V_W'(r_amount);
        move_cand = scale_u[C-1] ? (acc_s - amt_v) : (acc_s + amt_v);
    end

    // shared multiplier: range limit first, then the preset product
    assign mul_a = cmd.mul_preset ? r_amt_min : r_span;
    assign mul_b = signed'({1'b0, r_d});
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (cmd.ld_setup) begin
            r_min     <= f_min;
            r_d       <= d_sel;
            r_span    <= span;
            r_amt_min <= amt_min;
            r_cand    <= move_cand;
        end
        if (cmd.mul_limit) begin
            r_lim <= mul_p;
        end
        if (cmd.mul_preset) begin
            r_cand <= mul_p + signed'(V_W'(r_d[C-1:1]));
        end
    end

    always_comb begin
        span_pos = !r_span[SPAN_W-1] && (r_span != '0);
        if (!span_pos || r_cand[V_W-1]) begin
            clamp_wide = '0;
        end else if (r_cand >= r_lim) begin
            clamp_wide = r_lim - V_W'(1);
        end else begin
            clamp_wide = r_cand;
        end
        clamp_v = clamp_wide[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_acc[i] <= '0;
            end
        end else if (cmd.clamp_en) begin
            r_acc[r_idx] <= clamp_v;
        end
    end

    bpaa_div #(
        .ACC_W (ACC_W),
        .DIV_W (C)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cmd.clamp_en),
        .i_dividend (clamp_v),
        .i_divisor  (r_d),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign n_position = r_bad ? '0 : (r_min + signed'(quotient[C-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_position <= n_position;
        end
    end

    assign i_item.ready      = cmd.in_ready;
    assign o_result.valid    = r_out_valid;
    assign o_result.position = r_position;

    `BPAA_ASSERT_NOW(a_clamp_below_limit, i_clk, i_rst_n, cmd.clamp_en && span_pos, clamp_wide < r_lim)
    `BPAA_ASSERT_NOW(a_load_after_divide, i_clk, i_rst_n, cmd.out_load, !div_busy && state == ST_DONE)
    `BPAA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !i_item.ready)

endmodule

`default_nettype wire
